FILE: sv/histogram_percentile_contrast_stretch_defines.svh
// assertion macros for the contrast stretch block
`ifndef HISTOGRAM_PERCENTILE_CONTRAST_STRETCH_DEFINES_SVH
`define HISTOGRAM_PERCENTILE_CONTRAST_STRETCH_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define HPCS_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define HPCS_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) pre |=> post) else $error(msg);
`else
`define HPCS_ASSERT(label, clk, rst_n, prop, msg)
`define HPCS_ASSERT_NEXT(label, clk, rst_n, pre, post, msg)
`endif
`endif

FILE: sv/hpcs_pkg.sv
`default_nettype none

package hpcs_pkg;

    localparam int PIXEL_BITS = 16;
    localparam int FRAC_BITS  = 17;
    localparam int Q_BITS     = 16;

    localparam logic [Q_BITS-1:0]    ONE_Q16     = 16'hFFFF;
    localparam logic [FRAC_BITS-1:0] FULL_WINDOW = 17'h10000;

    localparam logic REG_LOWER = 1'b0;
    localparam logic REG_UPPER = 1'b1;

    localparam logic ACT_LOAD  = 1'b0;
    localparam logic ACT_FETCH = 1'b1;

    typedef struct packed {
        logic load;
        logic clr;
        logic hist_rd;
        logic hmul;
        logic div_start;
        logic hbin;
        logic hbwr;
        logic srch_rd;
        logic srch_acc;
        logic fetch_rd;
        logic fcalc;
        logic fnorm;
        logic fdone;
    } cmd_t;

    typedef struct packed {
        logic last_bin;
        logic last_pix;
        logic div_done;
        logic out_free;
        logic last_fetch;
    } stat_t;

endpackage

`default_nettype wire

FILE: sv/hpcs_div.sv
`default_nettype none

module hpcs_div #(
    parameter int XW = 43,
    parameter int SW = 27,
    parameter int QB = 16
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire logic [XW-1:0] dividend,
    input  wire logic [SW-1:0] divisor,
    output logic      [QB-1:0] quotient,
    output logic               done
);

    localparam int KW = $clog2(QB);

    logic [XW-1:0] rem_reg;
    logic [XW-1:0] dsh_reg;
    logic [QB-1:0] q_reg;
    logic [KW-1:0] cnt_reg;
    logic          busy_reg;
    logic          done_reg;
    logic          ge;

    assign ge = rem_reg >= dsh_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                if (cnt_reg == KW'(QB - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                end
            end
        end
    end

    // one quotient bit per cycle, restoring
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= dividend;
            dsh_reg <= XW'(divisor) << (QB - 1);
            q_reg   <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? rem_reg - dsh_reg : rem_reg;
            dsh_reg <= dsh_reg >> 1;
            q_reg   <= {q_reg[QB-2:0], ge};
        end
    end

    assign quotient = q_reg;
    assign done     = done_reg;

endmodule

`default_nettype wire

FILE: sv/hpcs_datapath.sv
`default_nettype none
`include "histogram_percentile_contrast_stretch_defines.svh"

module hpcs_datapath #(
    parameter int MAX_PIXELS = 65536,
    parameter int BINS       = 512
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire hpcs_pkg::cmd_t                       cmd,
    output hpcs_pkg::stat_t                           stat,
    input  wire logic [hpcs_pkg::PIXEL_BITS-1:0]      pixel_value,
    input  wire logic                                 cfg_write_en,
    input  wire logic                                 cfg_index,
    input  wire logic [hpcs_pkg::FRAC_BITS-1:0]       cfg_data,
    output logic                                      out_valid,
    input  wire logic                                 out_ready,
    output logic      [hpcs_pkg::Q_BITS-1:0]          normalized_pixel,
    output logic                                      last_out
);

    localparam int PB = hpcs_pkg::PIXEL_BITS;
    localparam int FB = hpcs_pkg::FRAC_BITS;
    localparam int QB = hpcs_pkg::Q_BITS;
    localparam int AW = $clog2(MAX_PIXELS);
    localparam int CW = $clog2(MAX_PIXELS + 1);
    localparam int BW = $clog2(BINS);
    localparam int MW = PB + BW;
    localparam int SW = PB + BW + 2;
    localparam int XW = SW + PB;
    localparam int LW = FB + CW;

    logic [PB-1:0] pixel_store [MAX_PIXELS];
    logic [CW-1:0] bin_counts [BINS];

    logic [FB-1:0] lf_reg, uf_reg;
    logic [PB-1:0] min_reg, max_reg;
    logic [CW-1:0] count_reg, rp_reg, pidx_reg;
    logic [BW-1:0] bidx_reg, bin_reg, lower_reg, upper_reg;
    logic          window_reg, lfound_reg, ufound_reg;
    logic [LW-1:0] lprod_reg, uprod_reg;
    logic [CW:0]   acc_reg;
    logic [PB-1:0] pix_rd_reg, d_reg;
    logic [CW-1:0] bin_rd_reg;
    logic [MW-1:0] dm_reg, lm_reg;
    logic signed [SW-1:0] den_reg;
    logic [XW-1:0] dividend_reg;
    logic [SW-1:0] divisor_reg;
    logic          zero_reg, one_reg;
    logic          out_valid_reg, out_last_reg;
    logic [QB-1:0] out_pix_reg;

    logic [PB-1:0] span, d_now;
    logic          flat;
    logic [QB-1:0] quotient;
    logic          div_done;
    logic [BW-1:0] bin_next;
    logic [AW-1:0] st_addr;
    logic [BW-1:0] b_addr;
    logic [CW:0]   acc_next, lsum, usum;
    logic signed [BW:0]   bdiff;
    logic signed [SW-1:0] den_next, num_s, den_s, nm_s, dn_s;
    logic          neg, zero_next, one_next;
    logic [XW-1:0] dividend_next;

    assign span  = max_reg - min_reg;
    assign flat  = max_reg <= min_reg;
    assign d_now = pix_rd_reg - min_reg;
    assign lsum  = lprod_reg[LW-1:16];
    assign usum  = uprod_reg[LW-1:16];
    assign acc_next = acc_reg + (CW + 1)'(bin_rd_reg);

    assign bin_next = flat ? '0 :
                      (quotient > QB'(BINS - 1)) ? BW'(BINS - 1) : quotient[BW-1:0];
    assign st_addr  = cmd.fetch_rd ? rp_reg[AW-1:0] : pidx_reg[AW-1:0];
    assign b_addr   = cmd.hbin ? bin_next : bidx_reg;

    assign bdiff    = $signed({1'b0, upper_reg}) - $signed({1'b0, lower_reg});
    assign den_next = bdiff * $signed({1'b0, span});

    always_comb
    begin
        num_s = window_reg ? ($signed(SW'(dm_reg)) - $signed(SW'(lm_reg)))
                           : $signed(SW'(d_reg));
        den_s = window_reg ? den_reg : $signed(SW'(span));
        neg   = den_s[SW-1];
        nm_s  = neg ? -num_s : num_s;
        dn_s  = neg ? -den_s : den_s;
        zero_next = flat || (window_reg && (upper_reg == lower_reg))
                    || (nm_s <= 0) || (dn_s == 0);
        one_next  = nm_s >= dn_s;
        dividend_next = (XW'($unsigned(nm_s)) << PB) - XW'($unsigned(nm_s));
    end

    hpcs_div #(
        .XW(XW),
        .SW(SW),
        .QB(QB)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (dividend_reg),
        .divisor  (divisor_reg),
        .quotient (quotient),
        .done     (div_done)
    );

    // pixel store
    always_ff @(posedge clk)
    begin
        if (cmd.load && (count_reg < CW'(MAX_PIXELS)))
        begin
            pixel_store[count_reg[AW-1:0]] <= pixel_value;
        end
        if (cmd.hist_rd || cmd.fetch_rd)
        begin
            pix_rd_reg <= pixel_store[st_addr];
        end
    end

    // histogram memory
    always_ff @(posedge clk)
    begin
        if (cmd.clr)
        begin
            bin_counts[bidx_reg] <= '0;
        end
        else if (cmd.hbwr)
        begin
            bin_counts[bin_reg] <= bin_rd_reg + 1'b1;
        end
        if (cmd.hbin || cmd.srch_rd)
        begin
            bin_rd_reg <= bin_counts[b_addr];
        end
    end

    // arithmetic payload
    always_ff @(posedge clk)
    begin
        if (cmd.clr)
        begin
            lprod_reg <= LW'(lf_reg) * LW'(count_reg);
            uprod_reg <= LW'(uf_reg) * LW'(count_reg);
        end
        if (cmd.hmul)
        begin
            dividend_reg <= XW'(MW'(d_now) * MW'(BINS - 1));
            divisor_reg  <= SW'(span);
        end
        if (cmd.hbin)
        begin
            bin_reg <= bin_next;
        end
        if (cmd.fcalc)
        begin
            d_reg   <= d_now;
            dm_reg  <= MW'(d_now) * MW'(BINS - 1);
            lm_reg  <= MW'(lower_reg) * MW'(span);
            den_reg <= den_next;
        end
        if (cmd.fnorm)
        begin
            dividend_reg <= dividend_next;
            divisor_reg  <= $unsigned(dn_s);
            zero_reg     <= zero_next;
            one_reg      <= one_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lf_reg        <= '0;
            uf_reg        <= hpcs_pkg::FULL_WINDOW;
            min_reg       <= '1;
            max_reg       <= '0;
            count_reg     <= '0;
            rp_reg        <= '0;
            pidx_reg      <= '0;
            bidx_reg      <= '0;
            lower_reg     <= '0;
            upper_reg     <= BW'(BINS - 1);
            window_reg    <= 1'b0;
            lfound_reg    <= 1'b0;
            ufound_reg    <= 1'b0;
            acc_reg       <= '0;
            out_valid_reg <= 1'b0;
            out_last_reg  <= 1'b0;
            out_pix_reg   <= '0;
        end
        else
        begin
            if (cfg_write_en)
            begin
                case (cfg_index)
                    hpcs_pkg::REG_LOWER: lf_reg <= cfg_data;
                    hpcs_pkg::REG_UPPER: uf_reg <= cfg_data;
                    default: ;
                endcase
            end

            if (cmd.load)
            begin
                bidx_reg <= '0;
                if (count_reg < CW'(MAX_PIXELS))
                begin
                    count_reg <= count_reg + 1'b1;
                    if (pixel_value < min_reg)
                    begin
                        min_reg <= pixel_value;
                    end
                    if (pixel_value > max_reg)
                    begin
                        max_reg <= pixel_value;
                    end
                end
            end

            if (cmd.clr)
            begin
                window_reg <= !((lf_reg == '0) && (uf_reg == hpcs_pkg::FULL_WINDOW));
                lower_reg  <= '0;
                upper_reg  <= BW'(BINS - 1);
                acc_reg    <= '0;
                lfound_reg <= 1'b0;
                ufound_reg <= 1'b0;
                pidx_reg   <= '0;
                bidx_reg   <= stat.last_bin ? '0 : bidx_reg + 1'b1;
            end

            if (cmd.hbwr)
            begin
                pidx_reg <= pidx_reg + 1'b1;
            end

            if (cmd.srch_acc)
            begin
                acc_reg  <= acc_next;
                bidx_reg <= stat.last_bin ? '0 : bidx_reg + 1'b1;
                if (!ufound_reg && (acc_next >= usum))
                begin
                    upper_reg  <= bidx_reg;
                    ufound_reg <= 1'b1;
                end
                if (!lfound_reg && (bidx_reg != '0) && (acc_next > lsum))
                begin
                    lower_reg  <= bidx_reg - 1'b1;
                    lfound_reg <= 1'b1;
                end
            end

            if (cmd.fdone)
            begin
                out_valid_reg <= 1'b1;
                out_last_reg  <= stat.last_fetch;
                out_pix_reg   <= zero_reg ? '0 : one_reg ? hpcs_pkg::ONE_Q16 : quotient;
                if (stat.last_fetch)
                begin
                    min_reg   <= '1;
                    max_reg   <= '0;
                    count_reg <= '0;
                    rp_reg    <= '0;
                end
                else
                begin
                    rp_reg <= rp_reg + 1'b1;
                end
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign stat.last_bin   = bidx_reg == BW'(BINS - 1);
    assign stat.last_pix   = CW'(pidx_reg + 1'b1) == count_reg;
    assign stat.div_done   = div_done;
    assign stat.out_free   = !out_valid_reg || out_ready;
    assign stat.last_fetch = CW'(rp_reg + 1'b1) == count_reg;

    assign out_valid        = out_valid_reg;
    assign normalized_pixel = out_pix_reg;
    assign last_out         = out_last_reg;

    `HPCS_ASSERT(a_count_bound, clk, rst_n, count_reg <= CW'(MAX_PIXELS), "pixel count overflow")
    `HPCS_ASSERT(a_extremes, clk, rst_n, (count_reg == '0) || (min_reg <= max_reg), "min above max")
    `HPCS_ASSERT(a_fetch_range, clk, rst_n, cmd.fetch_rd |-> (rp_reg < count_reg), "read past image")
    `HPCS_ASSERT_NEXT(a_out_set, clk, rst_n, cmd.fdone, out_valid_reg, "result not presented")

endmodule

`default_nettype wire

FILE: sv/hpcs_ctrl.sv
`default_nettype none

module hpcs_ctrl (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire logic            action,
    input  wire logic            last_pixel,
    input  wire hpcs_pkg::stat_t stat,
    output hpcs_pkg::cmd_t       cmd
);

    typedef enum logic [15:0] {
        S_LOAD  = 16'h0001,
        S_CLR   = 16'h0002,
        S_HRD   = 16'h0004,
        S_HMUL  = 16'h0008,
        S_HST   = 16'h0010,
        S_HDIV  = 16'h0020,
        S_HBIN  = 16'h0040,
        S_HBWR  = 16'h0080,
        S_SRD   = 16'h0100,
        S_SACC  = 16'h0200,
        S_OUT   = 16'h0400,
        S_FRD   = 16'h0800,
        S_FCALC = 16'h1000,
        S_FNORM = 16'h2000,
        S_FST   = 16'h4000,
        S_FDIV  = 16'h8000
    } state_t;

    state_t state_reg, state_next;
    logic   fdone_wait_reg, fdone_wait_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_LOAD;
            fdone_wait_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            fdone_wait_reg <= fdone_wait_next;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        fdone_wait_next = fdone_wait_reg;
        cmd             = '0;
        in_ready        = 1'b0;
        case (state_reg)
            S_LOAD:
            begin
                in_ready = 1'b1;
                if (in_valid && (action == hpcs_pkg::ACT_LOAD))
                begin
                    cmd.load = 1'b1;
                    if (last_pixel)
                    begin
                        state_next = S_CLR;
                    end
                end
            end
            S_CLR:
            begin
                cmd.clr = 1'b1;
                if (stat.last_bin)
                begin
                    state_next = S_HRD;
                end
            end
            S_HRD:
            begin
                cmd.hist_rd = 1'b1;
                state_next  = S_HMUL;
            end
            S_HMUL:
            begin
                cmd.hmul   = 1'b1;
                state_next = S_HST;
            end
            S_HST:
            begin
                cmd.div_start = 1'b1;
                state_next    = S_HDIV;
            end
            S_HDIV:
            begin
                if (stat.div_done)
                begin
                    state_next = S_HBIN;
                end
            end
            S_HBIN:
            begin
                cmd.hbin   = 1'b1;
                state_next = S_HBWR;
            end
            S_HBWR:
            begin
                cmd.hbwr   = 1'b1;
                state_next = stat.last_pix ? S_SRD : S_HRD;
            end
            S_SRD:
            begin
                cmd.srch_rd = 1'b1;
                state_next  = S_SACC;
            end
            S_SACC:
            begin
                cmd.srch_acc = 1'b1;
                state_next   = stat.last_bin ? S_OUT : S_SRD;
            end
            S_OUT:
            begin
                in_ready = 1'b1;
                if (in_valid && (action == hpcs_pkg::ACT_FETCH))
                begin
                    state_next = S_FRD;
                end
            end
            S_FRD:
            begin
                cmd.fetch_rd = 1'b1;
                state_next   = S_FCALC;
            end
            S_FCALC:
            begin
                cmd.fcalc  = 1'b1;
                state_next = S_FNORM;
            end
            S_FNORM:
            begin
                cmd.fnorm  = 1'b1;
                state_next = S_FST;
            end
            S_FST:
            begin
                cmd.div_start = 1'b1;
                state_next    = S_FDIV;
            end
            S_FDIV:
            begin
                // hold the quotient until the output register frees up
                if (stat.div_done || fdone_wait_reg)
                begin
                    if (stat.out_free)
                    begin
                        cmd.fdone       = 1'b1;
                        fdone_wait_next = 1'b0;
                        state_next      = stat.last_fetch ? S_LOAD : S_OUT;
                    end
                    else
                    begin
                        fdone_wait_next = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: sv/histogram_percentile_contrast_stretch.sv
// loads: one pixel per cycle, the last pixel starts the close pass
// close pass: clear every bin, bin each pixel through the divider, then search the cumulative histogram
// fetch: one request at a time (read, calc, normalize, divide), 16-step divider; waits while the output is held
// pixel store reads are registered; one image is held at a time
// reset (async, active low): loading phase, window 0..1, histogram cleared by each close pass
`default_nettype none

module histogram_percentile_contrast_stretch #(
    parameter int MAX_PIXELS = 65536,
    parameter int BINS       = 512
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    output logic                                     in_ready,
    input  wire logic                                action,
    input  wire logic [hpcs_pkg::PIXEL_BITS-1:0]     pixel_value,
    input  wire logic                                last_pixel,
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output logic      [hpcs_pkg::Q_BITS-1:0]         normalized_pixel,
    output logic                                     last_out,
    input  wire logic                                cfg_write_en,
    input  wire logic                                cfg_index,
    input  wire logic [hpcs_pkg::FRAC_BITS-1:0]      cfg_data
);

    hpcs_pkg::cmd_t  cmd;
    hpcs_pkg::stat_t stat;

    hpcs_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .action     (action),
        .last_pixel (last_pixel),
        .stat       (stat),
        .cmd        (cmd)
    );

    hpcs_datapath #(
        .MAX_PIXELS(MAX_PIXELS),
        .BINS      (BINS)
    ) u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .stat             (stat),
        .pixel_value      (pixel_value),
        .cfg_write_en     (cfg_write_en),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .normalized_pixel (normalized_pixel),
        .last_out         (last_out)
    );

endmodule

`default_nettype wire
